@@ rtl/core/ldgc_pkg.sv @@
`timescale 1ns / 1ps
package ldgc_pkg;

  localparam int EXTENT_MAX  = 16;
  localparam int SITE_COUNT  = 65536;
  localparam int COLOR_LIMIT = 255;
  localparam int DIST_MAX    = 3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_COLORED = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_NOFREE  = 2'd3;

  localparam logic REQ_COLOR = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [2:0] REG_EXT_T = 3'd0;
  localparam logic [2:0] REG_EXT_Z = 3'd1;
  localparam logic [2:0] REG_EXT_Y = 3'd2;
  localparam logic [2:0] REG_EXT_X = 3'd3;
  localparam logic [2:0] REG_DIST  = 3'd4;

  typedef struct packed {
    logic valid;
    logic last;
  } walk_ctl_t;

  function automatic logic signed [3:0] absv(input logic signed [3:0] v);
    absv = (v < 0) ? -v : v;
  endfunction

  function automatic logic [4:0] clamp_ext(input logic [4:0] e);
    clamp_ext = (e > 5'(EXTENT_MAX)) ? 5'(EXTENT_MAX) : e;
  endfunction

  // true modulo of c + dlt, |dlt| <= 3 so three corrections suffice
  function automatic logic [3:0] wrap(input logic [3:0] c, input logic signed [3:0] dlt,
                                      input logic [4:0] e);
    logic signed [6:0] v;
    v = signed'({3'b000, c}) + 7'(dlt);
    for (int i = 0; i < 3; i++) begin
      if (v < 0) v = v + signed'({2'b00, e});
    end
    for (int i = 0; i < 3; i++) begin
      if (v >= signed'({2'b00, e})) v = v - signed'({2'b00, e});
    end
    wrap = v[3:0];
  endfunction

endpackage

@@ rtl/core/ldgc_walk.sv @@
`timescale 1ns / 1ps
module ldgc_walk (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [1:0]          dist_lim,
  input  logic [3:0]          ct,
  input  logic [3:0]          cz,
  input  logic [3:0]          cy,
  input  logic [3:0]          cx,
  input  logic [4:0]          et,
  input  logic [4:0]          ez,
  input  logic [4:0]          ey,
  input  logic [4:0]          ex,
  output logic [15:0]         slot,
  output ldgc_pkg::walk_ctl_t ctl
);
  import ldgc_pkg::*;

  logic run;
  logic signed [3:0] dt, dz, dy, dx;
  logic signed [3:0] dt_next, dz_next, dy_next, dx_next;
  logic signed [3:0] sd, r1, r2, r3, tmp;

  // visits every offset with l1 norm <= d, one per cycle
  always_comb begin
    sd = signed'({2'b00, dist_lim});
    r1 = sd - absv(dt);
    r2 = r1 - absv(dz);
    r3 = r2 - absv(dy);
    tmp = 4'sd0;
    dt_next = dt;
    dz_next = dz;
    dy_next = dy;
    dx_next = dx;
    if (dx < r3) begin
      dx_next = dx + 4'sd1;
    end else if (dy < r2) begin
      dy_next = dy + 4'sd1;
      tmp = r2 - absv(dy + 4'sd1);
      dx_next = -tmp;
    end else if (dz < r1) begin
      dz_next = dz + 4'sd1;
      tmp = r1 - absv(dz + 4'sd1);
      dy_next = -tmp;
      dx_next = 4'sd0;
    end else begin
      dt_next = dt + 4'sd1;
      tmp = sd - absv(dt + 4'sd1);
      dz_next = -tmp;
      dy_next = 4'sd0;
      dx_next = 4'sd0;
    end
  end

  always_ff @(posedge clk) begin
    slot <= {wrap(ct, dt, et), wrap(cz, dz, ez), wrap(cy, dy, ey), wrap(cx, dx, ex)};
    if (rst) begin
      run <= 1'b0;
      ctl <= '0;
    end else begin
      ctl.valid <= run;
      ctl.last  <= run && (dt == sd);
      if (go) begin
        run <= 1'b1;
        dt  <= -sd;
        dz  <= 4'sd0;
        dy  <= 4'sd0;
        dx  <= 4'sd0;
      end else if (run) begin
        if (dt == sd) begin
          run <= 1'b0;
        end else begin
          dt <= dt_next;
          dz <= dz_next;
          dy <= dy_next;
          dx <= dx_next;
        end
      end
    end
  end

endmodule

@@ rtl/core/lattice_distance_greedy_coloring_core.sv @@
`timescale 1ns / 1ps
// Greedy distance-d coloring of a periodic 4d lattice of up to 16^4 sites. Raise start
// for one cycle while busy is low; the word comes back on color, max_color and status
// with done high for exactly one cycle, and the receiver cannot stall it. A color request
// walks the N sites within the l1 distance through a single color store read port, one
// site per cycle, and then runs a 16-color-per-cycle search for the free color, N being
// 129 at distance 3, 41 at 2, 9 at 1 and 1 at 0. An already colored request holds busy
// only through the look-up and check states, and an out of range request answers right
// after the accepting edge without raising busy. A clear request, and also reset, sweeps
// the 65536-entry store one entry per cycle, holding busy high until the sweep ends.
// Configuration writes belong between requests.
module lattice_distance_greedy_coloring_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [3:0]  coord_t,
  input  logic [3:0]  coord_z,
  input  logic [3:0]  coord_y,
  input  logic [3:0]  coord_x,
  output logic        done,
  output logic [7:0]  color,
  output logic [7:0]  max_color,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ldgc_pkg::*;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_LOOK, S_CHK, S_WALK, S_SCAN, S_WRITE
  } state_t;

  state_t state;
  logic        clr_req;
  logic [15:0] clr_cnt;
  logic [4:0]  ext_t, ext_z, ext_y, ext_x;
  logic [1:0]  dist_lim;
  logic [4:0]  et, ez, ey, ex;
  logic [3:0]  ct, cz, cy, cx;
  logic [15:0] target;
  logic [7:0]  run_max;
  logic [255:0] used;
  logic [3:0]  chunk_k;
  logic [15:0] chunk;
  logic        found;
  logic [3:0]  found_idx;
  logic [7:0]  new_col;
  logic        go;
  logic [15:0] walk_slot;
  walk_ctl_t   wctl;
  walk_ctl_t   wctl_q;
  logic        in_range;
  logic [7:0]  mem [SITE_COUNT];
  logic [15:0] raddr, waddr;
  logic [7:0]  rdata, wdata;
  logic        we;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_t    <= 5'd16;
      ext_z    <= 5'd16;
      ext_y    <= 5'd16;
      ext_x    <= 5'd16;
      dist_lim <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_EXT_T: ext_t    <= pwdata[4:0];
        REG_EXT_Z: ext_z    <= pwdata[4:0];
        REG_EXT_Y: ext_y    <= pwdata[4:0];
        REG_EXT_X: ext_x    <= pwdata[4:0];
        REG_DIST:  dist_lim <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_EXT_T: prdata = {27'd0, ext_t};
      REG_EXT_Z: prdata = {27'd0, ext_z};
      REG_EXT_Y: prdata = {27'd0, ext_y};
      REG_EXT_X: prdata = {27'd0, ext_x};
      REG_DIST:  prdata = {30'd0, dist_lim};
      default:   prdata = 32'd0;
    endcase
  end

  assign et = clamp_ext(ext_t);
  assign ez = clamp_ext(ext_z);
  assign ey = clamp_ext(ext_y);
  assign ex = clamp_ext(ext_x);
  assign in_range = ({1'b0, coord_t} < et) && ({1'b0, coord_z} < ez) &&
                    ({1'b0, coord_y} < ey) && ({1'b0, coord_x} < ex);

  ldgc_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .dist_lim (dist_lim),
    .ct       (ct),
    .cz       (cz),
    .cy       (cy),
    .cx       (cx),
    .et       (et),
    .ez       (ez),
    .ey       (ey),
    .ex       (ex),
    .slot     (walk_slot),
    .ctl      (wctl)
  );

  // color store
  assign raddr = (state == S_LOOK) ? target : walk_slot;
  assign we    = (state == S_CLR) || (state == S_WRITE);
  assign waddr = (state == S_CLR) ? clr_cnt : target;
  assign wdata = (state == S_CLR) ? 8'd0 : new_col;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // walk flags lined up with the store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      wctl_q <= '0;
    end else begin
      wctl_q <= wctl;
    end
  end

  // first free color, 16 at a time; color 0 never counts
  always_comb begin
    chunk = used[{chunk_k, 4'd0} +: 16];
    if (chunk_k == 4'd0) chunk[0] = 1'b1;
    found = 1'b0;
    found_idx = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (!chunk[i]) begin
        found = 1'b1;
        found_idx = 4'(i);
      end
    end
  end

  assign go   = (state == S_CHK) && (rdata == 8'd0);
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_req   <= 1'b0;
      clr_cnt   <= '0;
      run_max   <= '0;
      done      <= 1'b0;
      chunk_k   <= '0;
      used      <= '0;
      new_col   <= '0;
      color     <= '0;
      max_color <= '0;
      status    <= ST_OK;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 16'd1;
          if (clr_cnt == 16'(SITE_COUNT - 1)) begin
            state <= S_IDLE;
            if (clr_req) begin
              done      <= 1'b1;
              color     <= 8'd0;
              max_color <= 8'd0;
              status    <= ST_OK;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            ct <= coord_t;
            cz <= coord_z;
            cy <= coord_y;
            cx <= coord_x;
            target <= {coord_t, coord_z, coord_y, coord_x};
            if (req_type == REQ_CLEAR) begin
              state   <= S_CLR;
              clr_req <= 1'b1;
              clr_cnt <= '0;
              run_max <= '0;
            end else if (!in_range) begin
              done      <= 1'b1;
              color     <= 8'd0;
              max_color <= run_max;
              status    <= ST_RANGE;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: state <= S_CHK;
        S_CHK: begin
          if (rdata != 8'd0) begin
            state     <= S_IDLE;
            done      <= 1'b1;
            color     <= rdata;
            max_color <= run_max;
            status    <= ST_COLORED;
          end else begin
            state <= S_WALK;
            used  <= '0;
          end
        end
        S_WALK: begin
          if (wctl_q.valid) used[rdata] <= 1'b1;
          if (wctl_q.valid && wctl_q.last) begin
            state   <= S_SCAN;
            chunk_k <= '0;
          end
        end
        S_SCAN: begin
          chunk_k <= chunk_k + 4'd1;
          if (found && ({chunk_k, found_idx} <= 8'(COLOR_LIMIT))) begin
            state   <= S_WRITE;
            new_col <= {chunk_k, found_idx};
          end else if (found || chunk_k == 4'd15) begin
            state     <= S_IDLE;
            done      <= 1'b1;
            color     <= 8'd0;
            max_color <= run_max;
            status    <= ST_NOFREE;
          end
        end
        S_WRITE: begin
          state     <= S_IDLE;
          done      <= 1'b1;
          color     <= new_col;
          status    <= ST_OK;
          max_color <= (new_col > run_max) ? new_col : run_max;
          run_max   <= (new_col > run_max) ? new_col : run_max;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !(req_type == REQ_COLOR && !in_range) |=> busy)
    else $error("accepted word did not raise busy");

  a_ok_color: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_OK && state == S_IDLE && $past(state) == S_WRITE |->
      color != 8'd0 && max_color >= color)
    else $error("assigned color zero or above running max");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while busy");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import ldgc_pkg::*;

  typedef struct {
    logic [7:0] color;
    logic [7:0] max_color;
    logic [1:0] status;
  } color_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type = REQ_COLOR;
  logic [3:0]  coord_t = '0;
  logic [3:0]  coord_z = '0;
  logic [3:0]  coord_y = '0;
  logic [3:0]  coord_x = '0;
  logic        done;
  logic [7:0]  color;
  logic [7:0]  max_color;
  logic [1:0]  status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lattice_distance_greedy_coloring_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .coord_t(coord_t), .coord_z(coord_z), .coord_y(coord_y), .coord_x(coord_x),
    .done(done), .color(color), .max_color(max_color), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the block state
  logic [7:0] lattice_colors [SITE_COUNT];
  logic [7:0] top_color = '0;
  logic [4:0] extent [4] = '{5'd16, 5'd16, 5'd16, 5'd16};
  logic [1:0] dist_reg = 2'd1;

  color_word_t expected_words [$];
  int errors = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic predict_coloring(input logic req, input logic [3:0] c [4]);
    color_word_t w;
    int e [4];
    int d, v, n [4];
    logic [255:0] used;
    int col;
    logic [15:0] slot;
    logic [7:0] nc;
    logic in_range;
    if (req == REQ_CLEAR) begin
      foreach (lattice_colors[i]) lattice_colors[i] = '0;
      top_color = '0;
      w = '{8'd0, 8'd0, ST_OK};
    end else begin
      in_range = 1'b1;
      for (int i = 0; i < 4; i++) begin
        e[i] = (extent[i] > 5'd16) ? 16 : int'(extent[i]);
        if (int'(c[i]) >= e[i]) in_range = 1'b0;
      end
      slot = {c[0], c[1], c[2], c[3]};
      if (!in_range) begin
        w = '{8'd0, top_color, ST_RANGE};
      end else if (lattice_colors[slot] != 0) begin
        w = '{lattice_colors[slot], top_color, ST_COLORED};
      end else begin
        d = int'(dist_reg);
        used = '0;
        for (int dt = -d; dt <= d; dt++)
          for (int dz = -d; dz <= d; dz++)
            for (int dy = -d; dy <= d; dy++)
              for (int dx = -d; dx <= d; dx++) begin
                int dl [4];
                int l1;
                dl = '{dt, dz, dy, dx};
                l1 = 0;
                for (int i = 0; i < 4; i++) l1 += (dl[i] < 0) ? -dl[i] : dl[i];
                if (l1 <= d && l1 != 0) begin
                  for (int i = 0; i < 4; i++) begin
                    v = (int'(c[i]) + dl[i]) % e[i];
                    if (v < 0) v += e[i];
                    n[i] = v;
                  end
                  nc = lattice_colors[{n[0][3:0], n[1][3:0], n[2][3:0], n[3][3:0]}];
                  if (nc != 0) used[nc] = 1'b1;
                end
              end
        col = 1;
        while (col <= COLOR_LIMIT && used[col]) col++;
        if (col > COLOR_LIMIT) begin
          w = '{8'd0, top_color, ST_NOFREE};
        end else begin
          lattice_colors[slot] = col[7:0];
          if (col[7:0] > top_color) top_color = col[7:0];
          w = '{col[7:0], top_color, ST_OK};
        end
      end
    end
    expected_words.push_back(w);
  endtask

  task automatic send_word(input logic req, input logic [3:0] t, z, y, x, input int gap);
    logic [3:0] c [4];
    bit taken;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= req;
    coord_t <= t;
    coord_z <= z;
    coord_y <= y;
    coord_x <= x;
    c = '{t, z, y, x};
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      if (!busy) begin
        taken = 1;
        predict_coloring(req, c);
      end
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_EXT_T: extent[0] = val[4:0];
      REG_EXT_Z: extent[1] = val[4:0];
      REG_EXT_Y: extent[2] = val[4:0];
      REG_EXT_X: extent[3] = val[4:0];
      REG_DIST:  dist_reg = val[1:0];
      default: ;
    endcase
  endtask

  task automatic set_lattice(input logic [4:0] et, ez, ey, ex, input logic [1:0] d);
    set_reg(REG_EXT_T, {$urandom} & 32'hFFFF_FFE0 | 32'(et));
    set_reg(REG_EXT_Z, {$urandom} & 32'hFFFF_FFE0 | 32'(ez));
    set_reg(REG_EXT_Y, {$urandom} & 32'hFFFF_FFE0 | 32'(ey));
    set_reg(REG_EXT_X, {$urandom} & 32'hFFFF_FFE0 | 32'(ex));
    set_reg(REG_DIST, {$urandom} & 32'hFFFF_FFFC | 32'(d));
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    color_word_t w;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: color %0d max_color %0d status %0d",
               color, max_color, status);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (color !== w.color) begin
          $error("color: expected %0d, actual %0d", w.color, color);
          errors++;
        end
        if (max_color !== w.max_color) begin
          $error("max_color: expected %0d, actual %0d", w.max_color, max_color);
          errors++;
        end
        if (status !== w.status) begin
          $error("status: expected %0d, actual %0d", w.status, status);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_word(REQ_COLOR, 0, 0, 0, 0, 0);
    send_word(REQ_COLOR, 0, 0, 0, 0, 0);
    send_word(REQ_COLOR, 0, 0, 0, 1, 2);
    send_word(REQ_COLOR, 0, 0, 0, 15, 0);
    send_word(REQ_COLOR, 15, 0, 0, 0, 0);
    send_word(REQ_COLOR, 15, 15, 15, 15, 1);
    send_word(REQ_COLOR, 1, 1, 1, 1, 0);
    wait_idle();
    set_lattice(5'd31, 5'd16, 5'd16, 5'd20, 2'd0);
    send_word(REQ_COLOR, 2, 2, 2, 2, 0);
    send_word(REQ_COLOR, 2, 2, 2, 3, 0);
    wait_idle();
    set_lattice(5'd16, 5'd16, 5'd16, 5'd16, 2'd3);
    send_word(REQ_COLOR, 0, 0, 1, 1, 0);
    send_word(REQ_COLOR, 0, 0, 0, 2, 0);
    send_word(REQ_COLOR, 15, 15, 15, 14, 3);
    wait_idle();
    set_lattice(5'd0, 5'd2, 5'd1, 5'd3, 2'd3);
    send_word(REQ_COLOR, 0, 0, 0, 0, 0);
    wait_idle();
    set_lattice(5'd2, 5'd2, 5'd1, 5'd3, 2'd3);
    send_word(REQ_COLOR, 0, 2, 0, 0, 0);
    send_word(REQ_COLOR, 0, 0, 1, 0, 0);
    send_word(REQ_COLOR, 0, 0, 0, 3, 0);
    send_word(REQ_COLOR, 1, 1, 0, 2, 0);
    send_word(REQ_COLOR, 0, 0, 0, 0, 0);
    send_word(REQ_COLOR, 1, 0, 0, 1, 0);
    wait_idle();
  endtask

  task automatic test_clear();
    send_word(REQ_CLEAR, 4'hF, 4'hA, 4'h5, 4'h0, 0);
    send_word(REQ_COLOR, 0, 0, 0, 0, 0);
    wait_idle();
    set_lattice(5'd1, 5'd1, 5'd1, 5'd1, 2'd3);
    send_word(REQ_COLOR, 0, 0, 0, 0, 0);
    send_word(REQ_COLOR, 0, 0, 0, 1, 0);
    wait_idle();
  endtask

  task automatic test_random_lattice(input int count, input logic [4:0] et, ez, ey, ex,
                                     input logic [1:0] d);
    logic [4:0] ext [4];
    logic [3:0] c [4];
    bit steady;
    int g;
    set_lattice(et, ez, ey, ex, d);
    ext = '{et, ez, ey, ex};
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) steady = ($urandom_range(3) == 0);
      for (int i = 0; i < 4; i++) begin
        int lim;
        lim = (ext[i] > 5'd16) ? 16 : int'(ext[i]);
        if (lim == 0 || $urandom_range(99) < 12) c[i] = 4'($urandom);
        else c[i] = 4'($urandom_range(lim - 1));
      end
      g = steady ? 0 : pick_gap();
      if ($urandom_range(299) == 0) send_word(REQ_CLEAR, c[0], c[1], c[2], c[3], g);
      else send_word(REQ_COLOR, c[0], c[1], c[2], c[3], g);
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_clear();
    test_random_lattice(90, 5'd16, 5'd16, 5'd16, 5'd16, 2'd3);
    test_random_lattice(80, 5'd4, 5'd4, 5'd4, 5'd4, 2'd3);
    test_random_lattice(70, 5'd3, 5'd2, 5'd5, 5'd1, 2'd2);
    test_random_lattice(70, 5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                        5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                        2'($urandom_range(3)));
    test_random_lattice(60, 5'd0, 5'd25, 5'd8, 5'd31, 2'd1);
    test_random_lattice(80, 5'd6, 5'd5, 5'd3, 5'd7, 2'd3);
    test_random_lattice(70, 5'($urandom_range(1, 31)), 5'($urandom_range(1, 31)),
                        5'($urandom_range(1, 31)), 5'($urandom_range(1, 31)),
                        2'($urandom_range(3)));
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ldgc_pkg.sv
rtl/core/ldgc_walk.sv
rtl/core/lattice_distance_greedy_coloring_core.sv
tb/testbench.sv
